// ===== src/double_ended_fifo_with_remove_macros.svh =====
// Assertion macros shared by the checker of the double-ended queue.
`ifndef DOUBLE_ENDED_FIFO_WITH_REMOVE_MACROS_SVH
`define DOUBLE_ENDED_FIFO_WITH_REMOVE_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define DEFR_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("defr check failed");

// Implication checked at every clock edge out of reset.
`define DEFR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("defr check failed");

// Implication whose consequent is checked in the next cycle.
`define DEFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("defr check failed");

`endif

// ===== src/defr_pkg.sv =====
// Types, constants and helpers of the double-ended queue.
`default_nettype none
package defr_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int AW         = $clog2(DEPTH);
  localparam int CW         = $clog2(DEPTH + 1);

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [2:0] {
    CMD_APPEND    = 3'd0,
    CMD_PREPEND   = 3'd1,
    CMD_POP       = 3'd2,
    CMD_PEEK      = 3'd3,
    CMD_REMOVE    = 3'd4,
    CMD_DROP_HEAD = 3'd5,
    CMD_DROP_TAIL = 3'd6,
    CMD_CLEAR     = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NONE    = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // Offset used for a store read, relative to the head
  typedef enum logic [1:0] {
    RD_IDX  = 2'd0,
    RD_NEXT = 2'd1,
    RD_DROP = 2'd2
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_TAIL  = 2'd1,
    WR_HEAD  = 2'd2,
    WR_SHIFT = 2'd3
  } wr_sel_e;

  typedef enum logic [2:0] {
    UPD_NONE    = 3'd0,
    UPD_APPEND  = 3'd1,
    UPD_PREPEND = 3'd2,
    UPD_POP     = 3'd3,
    UPD_REMOVE  = 3'd4,
    UPD_DROP    = 3'd5
  } upd_e;

  // Controller to datapath
  typedef struct packed {
    logic    cap;
    logic    rd_en;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    upd_e    upd;
    logic    idx_inc;
    logic    ld_res;
    status_e res_status;
    logic    res_has;
    logic    res_last;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic data_zero;
    logic full;
    logic empty;
    logic idx_end;
    logic match;
    logic shf_end;
    logic n_zero;
    logic drop_last;
    logic res_last;
  } ctl_sts_t;

  // Circular index: head plus an offset of at most DEPTH
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(off);
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return AW'(s);
  endfunction

endpackage
`default_nettype wire

// ===== src/defr_if.sv =====
// Handshake channels of the double-ended queue: command in, result out.
`default_nettype none
interface defr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [31:0] data_value;
  logic [4:0]  amount;
  modport source (output valid, command, data_value, amount, input ready);
  modport sink (input valid, command, data_value, amount, output ready);
endinterface

interface defr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        has_value;
  logic [31:0] out_value;
  logic [4:0]  occupancy;
  logic        last_of_run;
  modport source (output valid, status, has_value, out_value, occupancy, last_of_run,
                  input ready);
  modport sink (input valid, status, has_value, out_value, occupancy, last_of_run,
                output ready);
endinterface
`default_nettype wire

// ===== src/defr_datapath.sv =====
// Datapath: entry store, head and count, item registers and result register.
`default_nettype none
module defr_datapath import defr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ctl_cmd_t    ctl_i,
  output ctl_sts_t         sts_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [31:0] data_value_i,
  input  wire logic [4:0]  amount_i,
  output logic [1:0]       status_o,
  output logic             has_value_o,
  output logic [31:0]      out_value_o,
  output logic [4:0]       occupancy_o,
  output logic             last_of_run_o
);

  word_t         mem_q [DEPTH];
  word_t         rdata_q;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, n_q, n_new;
  cmd_e          cmd_q;
  word_t         data_q;
  logic [1:0]    res_status_q;
  logic          res_has_q, res_last_q;
  logic [31:0]   res_value_q;
  logic [4:0]    res_occ_q;

  logic [AW-1:0] head_m1, rd_addr, wr_addr;
  logic [CW-1:0] rd_off, base, idx_p1;
  word_t         wr_data;
  logic          wr_en, is_drop;

  assign head_m1 = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
  assign idx_p1  = idx_q + CW'(1);
  assign is_drop = (cmd_q == CMD_DROP_HEAD) || (cmd_q == CMD_DROP_TAIL) ||
                   (cmd_q == CMD_CLEAR);
  assign base    = (cmd_q == CMD_DROP_TAIL) ? count_q - n_q : '0;

  // Number of entries a drop or clear takes away
  always_comb begin
    if (cmd_e'(command_i) == CMD_CLEAR || 8'(amount_i) > 8'(count_q)) begin
      n_new = count_q;
    end else begin
      n_new = CW'(amount_i);
    end
  end

  // Read address
  always_comb begin
    case (ctl_i.rd_sel)
      RD_NEXT: rd_off = idx_p1;
      RD_DROP: rd_off = base + idx_q;
      default: rd_off = idx_q;
    endcase
    rd_addr = wrap_add(head_q, rd_off);
  end

  // Write address and data
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = wrap_add(head_q, count_q);
    wr_data = data_q;
    unique case (ctl_i.wr_sel)
      WR_TAIL:  wr_addr = wrap_add(head_q, count_q);
      WR_HEAD:  wr_addr = head_m1;
      WR_SHIFT: begin
        wr_addr = wrap_add(head_q, idx_q);
        wr_data = rdata_q;
      end
      default:  wr_en = 1'b0;
    endcase
  end

  // Head and count update
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    unique case (ctl_i.upd)
      UPD_APPEND:  count_d = count_q + CW'(1);
      UPD_PREPEND: begin
        head_d  = head_m1;
        count_d = count_q + CW'(1);
      end
      UPD_POP: begin
        head_d  = wrap_add(head_q, CW'(1));
        count_d = count_q - CW'(1);
      end
      UPD_REMOVE:  count_d = count_q - CW'(1);
      UPD_DROP: begin
        count_d = count_q - n_q;
        if (cmd_q != CMD_DROP_TAIL) head_d = wrap_add(head_q, n_q);
      end
      default: ;
    endcase
  end

  // Entry store, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (ctl_i.rd_en) rdata_q <= mem_q[rd_addr];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      if (ctl_i.cap) idx_q <= '0;
      else if (ctl_i.idx_inc) idx_q <= idx_p1;
    end
  end

  // Item and result registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.cap) begin
      cmd_q  <= cmd_e'(command_i);
      data_q <= DATA_WIDTH'(data_value_i);
      n_q    <= n_new;
    end
    if (ctl_i.ld_res) begin
      res_status_q <= ctl_i.res_status;
      res_has_q    <= ctl_i.res_has;
      res_value_q  <= ctl_i.res_has ? 32'(rdata_q) : '0;
      res_occ_q    <= is_drop ? 5'(count_q - n_q) : 5'(count_d);
      res_last_q   <= ctl_i.res_last;
    end
  end

  assign sts_o.cmd       = cmd_q;
  assign sts_o.data_zero = (data_q == '0);
  assign sts_o.full      = (count_q == CW'(DEPTH));
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.idx_end   = (idx_q == count_q);
  assign sts_o.match     = (rdata_q == data_q);
  assign sts_o.shf_end   = ((CW+1)'(idx_q) + (CW+1)'(1) == (CW+1)'(count_q));
  assign sts_o.n_zero    = (n_q == '0);
  assign sts_o.drop_last = ((CW+1)'(idx_q) + (CW+1)'(1) == (CW+1)'(n_q));
  assign sts_o.res_last  = res_last_q;

  assign status_o      = res_status_q;
  assign has_value_o   = res_has_q;
  assign out_value_o   = res_value_q;
  assign occupancy_o   = res_occ_q;
  assign last_of_run_o = res_last_q;

endmodule
`default_nettype wire

// ===== src/defr_ctrl.sv =====
// Controller: sequences one command over the datapath and drives the handshakes.
`default_nettype none
module defr_ctrl import defr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire ctl_sts_t sts_i,
  output ctl_cmd_t      ctl_o
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_DECODE  = 10'b0000000010,
    S_POP_LD  = 10'b0000000100,
    S_SRCH_RD = 10'b0000001000,
    S_SRCH_CM = 10'b0000010000,
    S_SHF_RD  = 10'b0000100000,
    S_SHF_WR  = 10'b0001000000,
    S_DROP_RD = 10'b0010000000,
    S_DROP_LD = 10'b0100000000,
    S_EMIT    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_EMIT);

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    ctl_o.res_last = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.cap = 1'b1;
          state_d   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.cmd) inside
          CMD_APPEND, CMD_PREPEND: begin
            ctl_o.ld_res = 1'b1;
            state_d      = S_EMIT;
            if (sts_i.data_zero) begin
              ctl_o.res_status = ST_INVALID;
            end else if (sts_i.full) begin
              ctl_o.res_status = ST_FULL;
            end else begin
              ctl_o.res_status = ST_OK;
              ctl_o.wr_sel = (sts_i.cmd == CMD_APPEND) ? WR_TAIL : WR_HEAD;
              ctl_o.upd    = (sts_i.cmd == CMD_APPEND) ? UPD_APPEND : UPD_PREPEND;
            end
          end
          CMD_POP, CMD_PEEK: begin
            if (sts_i.empty) begin
              ctl_o.ld_res     = 1'b1;
              ctl_o.res_status = ST_NONE;
              state_d          = S_EMIT;
            end else begin
              ctl_o.rd_en = 1'b1;
              state_d     = S_POP_LD;
            end
          end
          CMD_REMOVE: begin
            if (sts_i.data_zero) begin
              ctl_o.ld_res     = 1'b1;
              ctl_o.res_status = ST_INVALID;
              state_d          = S_EMIT;
            end else begin
              state_d = S_SRCH_RD;
            end
          end
          default: begin
            if (sts_i.n_zero) begin
              ctl_o.ld_res = 1'b1;
              state_d      = S_EMIT;
            end else begin
              state_d = S_DROP_RD;
            end
          end
        endcase
      end
      S_POP_LD: begin
        ctl_o.ld_res  = 1'b1;
        ctl_o.res_has = 1'b1;
        ctl_o.upd     = (sts_i.cmd == CMD_POP) ? UPD_POP : UPD_NONE;
        state_d       = S_EMIT;
      end
      // Search from the head for the equal entry nearest the head
      S_SRCH_RD: begin
        if (sts_i.idx_end) begin
          ctl_o.ld_res     = 1'b1;
          ctl_o.res_status = ST_NONE;
          state_d          = S_EMIT;
        end else begin
          ctl_o.rd_en = 1'b1;
          state_d     = S_SRCH_CM;
        end
      end
      S_SRCH_CM: begin
        if (sts_i.match) begin
          state_d = S_SHF_RD;
        end else begin
          ctl_o.idx_inc = 1'b1;
          state_d       = S_SRCH_RD;
        end
      end
      // Close up the entries behind the removed one
      S_SHF_RD: begin
        if (sts_i.shf_end) begin
          ctl_o.ld_res = 1'b1;
          ctl_o.upd    = UPD_REMOVE;
          state_d      = S_EMIT;
        end else begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_sel = RD_NEXT;
          state_d      = S_SHF_WR;
        end
      end
      S_SHF_WR: begin
        ctl_o.wr_sel  = WR_SHIFT;
        ctl_o.idx_inc = 1'b1;
        state_d       = S_SHF_RD;
      end
      // Drops: one result per removed word
      S_DROP_RD: begin
        ctl_o.rd_en  = 1'b1;
        ctl_o.rd_sel = RD_DROP;
        state_d      = S_DROP_LD;
      end
      S_DROP_LD: begin
        ctl_o.ld_res   = 1'b1;
        ctl_o.res_has  = 1'b1;
        ctl_o.res_last = sts_i.drop_last;
        state_d        = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready_i) begin
          if (sts_i.res_last) begin
            if (sts_i.cmd == CMD_DROP_HEAD || sts_i.cmd == CMD_DROP_TAIL ||
                sts_i.cmd == CMD_CLEAR) begin
              ctl_o.upd = UPD_DROP;
            end
            state_d = S_IDLE;
          end else begin
            ctl_o.idx_inc = 1'b1;
            state_d       = S_DROP_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule
`default_nettype wire

// ===== src/double_ended_fifo_with_remove.sv =====
// Top level of the double-ended queue with search-and-remove.
// The queue holds up to DEPTH nonzero words and takes one command item at a
// time; the next item is accepted only after the last result of the previous
// one has been taken. A remove searches from the head and then closes up the
// entries behind the removed one; a drop or clear emits one result per word
// removed, or one result without a word when none is removed. The single-port
// store with its registered read is visited one entry at a time.
`default_nettype none
module double_ended_fifo_with_remove import defr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  defr_in_if.sink   in_i,
  defr_out_if.source out_o
);

  ctl_cmd_t ctl;
  ctl_sts_t sts;

  defr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  defr_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .command_i     (in_i.command),
    .data_value_i  (in_i.data_value),
    .amount_i      (in_i.amount),
    .status_o      (out_o.status),
    .has_value_o   (out_o.has_value),
    .out_value_o   (out_o.out_value),
    .occupancy_o   (out_o.occupancy),
    .last_of_run_o (out_o.last_of_run)
  );

endmodule
`default_nettype wire

// ===== src/defr_checker.sv =====
// Port-level checker of the double-ended queue and its bind.
`default_nettype none
`include "double_ended_fifo_with_remove_macros.svh"
module defr_checker import defr_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [1:0]  status_i,
  input wire logic        has_value_i,
  input wire logic [31:0] out_value_i,
  input wire logic        last_of_run_i
);

  // One item at a time: no new item while a result is offered
  `DEFR_ASSERT_ALWAYS(a_no_overlap, !(in_ready_i && out_valid_i))
  // A result without a word carries zero
  `DEFR_ASSERT_IMPL(a_zero_value, out_valid_i && !has_value_i, out_value_i == '0)
  // An error status ends the run and carries no word
  `DEFR_ASSERT_IMPL(a_err_single, out_valid_i && status_i != ST_OK,
                    last_of_run_i && !has_value_i)
  // A stalled result stays offered
  `DEFR_ASSERT_NEXT(a_hold, out_valid_i && !out_ready_i, out_valid_i)

endmodule

bind double_ended_fifo_with_remove defr_checker u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .has_value_i   (out_o.has_value),
  .out_value_i   (out_o.out_value),
  .last_of_run_i (out_o.last_of_run)
);
`default_nettype wire

// ===== tb/sv/defr_test_if.sv =====
// Result type shared by the testbench of the double-ended queue.
`default_nettype none
package defr_test_types_pkg;
  import defr_pkg::*;
  // One expected result of the queue
  typedef struct packed {
    status_e      status;
    logic         has_value;
    logic [31:0]  out_value;
    logic [4:0]   occupancy;
    logic         last_of_run;
  } defr_result_t;
endpackage
`default_nettype wire

// ===== tb/sv/double_ended_fifo_with_remove_test.sv =====
// Self-checking test of the double-ended queue: directed, random and back-pressure command items.
`default_nettype none
module double_ended_fifo_with_remove_test;
  import defr_pkg::*;
  import defr_test_types_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycle_count = 0;
  int   error_count = 0;
  bit   hold_off = 1'b0;

  defr_in_if  cmd_ch ();
  defr_out_if res_ch ();

  double_ended_fifo_with_remove u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch),
    .out_o  (res_ch)
  );

  // Clock
  always #5 clk_i = ~clk_i;

  // Shadow copy of the queue, head entry first
  logic [31:0]  shadow_q[$];
  defr_result_t expected_q[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
             cycle_count);
    error_count++;
  endtask

  function automatic defr_result_t make_result(status_e st, logic has, logic [31:0] v,
                                               logic last);
    defr_result_t r;
    r.status = st;
    r.has_value = has;
    r.out_value = has ? v : 32'd0;
    r.occupancy = 5'(shadow_q.size());
    r.last_of_run = last;
    return r;
  endfunction

  // Work out the results of one command and update the shadow queue
  task automatic predict_queue(input cmd_e cmd, input logic [31:0] data,
                               input logic [4:0] amount);
    logic [31:0] gone[$];
    int n;
    int found;
    gone = {};
    found = -1;
    case (cmd)
      CMD_APPEND, CMD_PREPEND: begin
        if (data == 0) expected_q.push_back(make_result(ST_INVALID, 0, 0, 1));
        else if (shadow_q.size() >= DEPTH)
          expected_q.push_back(make_result(ST_FULL, 0, 0, 1));
        else begin
          if (cmd == CMD_APPEND) shadow_q.push_back(data);
          else shadow_q.push_front(data);
          expected_q.push_back(make_result(ST_OK, 0, 0, 1));
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (shadow_q.size() == 0) expected_q.push_back(make_result(ST_NONE, 0, 0, 1));
        else begin
          logic [31:0] v;
          v = shadow_q[0];
          if (cmd == CMD_POP) void'(shadow_q.pop_front());
          expected_q.push_back(make_result(ST_OK, 1, v, 1));
        end
      end
      CMD_REMOVE: begin
        if (data == 0) expected_q.push_back(make_result(ST_INVALID, 0, 0, 1));
        else begin
          foreach (shadow_q[i]) if (found < 0 && shadow_q[i] == data) found = i;
          if (found >= 0) shadow_q.delete(found);
          expected_q.push_back(make_result(found >= 0 ? ST_OK : ST_NONE, 0, 0, 1));
        end
      end
      default: begin
        n = (cmd == CMD_CLEAR || amount > shadow_q.size()) ? shadow_q.size() : amount;
        if (cmd == CMD_DROP_TAIL) begin
          for (int i = shadow_q.size() - n; i < shadow_q.size(); i++)
            gone.push_back(shadow_q[i]);
          repeat (n) void'(shadow_q.pop_back());
        end else begin
          repeat (n) gone.push_back(shadow_q.pop_front());
        end
        if (n == 0) expected_q.push_back(make_result(ST_OK, 0, 0, 1));
        foreach (gone[i])
          expected_q.push_back(make_result(ST_OK, 1, gone[i], i == n - 1));
      end
    endcase
  endtask

  function automatic int short_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
           (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3));
  endfunction

  // Send one item; prediction happens at acceptance
  task automatic send_cmd(input cmd_e cmd, input logic [31:0] data,
                          input logic [4:0] amount, input bit no_gap = 0);
    cmd_ch.valid <= 1'b1;
    cmd_ch.command <= cmd;
    cmd_ch.data_value <= data;
    cmd_ch.amount <= amount;
    do @(posedge clk_i); while (!cmd_ch.ready);
    predict_queue(cmd, data, amount);
    @(negedge clk_i);
    if (!no_gap) begin
      int g;
      g = short_gap();
      if (g > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
    end
  endtask

  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Receiver readiness
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) res_ch.ready <= 1'b0;
      else res_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", res_ch.out_value, 32'd0);
      end else begin
        defr_result_t e;
        e = expected_q.pop_front();
        if (res_ch.status != e.status) report_mismatch("status", res_ch.status, e.status);
        if (res_ch.has_value != e.has_value)
          report_mismatch("has_value", res_ch.has_value, e.has_value);
        if (res_ch.out_value != e.out_value)
          report_mismatch("out_value", res_ch.out_value, e.out_value);
        if (res_ch.occupancy != e.occupancy)
          report_mismatch("occupancy", res_ch.occupancy, e.occupancy);
        if (res_ch.last_of_run != e.last_of_run)
          report_mismatch("last_of_run", res_ch.last_of_run, e.last_of_run);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("double_ended_fifo_with_remove_test: done, errors");
      $finish;
    end
  end

  function automatic logic [31:0] rand_word();
    return {$urandom()} | 32'd1;
  endfunction

  // Extremes and special cases
  task automatic test_directed();
    send_cmd(CMD_POP, 0, 0);
    send_cmd(CMD_PEEK, 0, 0);
    send_cmd(CMD_REMOVE, 32'h5, 0);
    send_cmd(CMD_DROP_HEAD, 0, 3);
    send_cmd(CMD_CLEAR, 0, 0);
    send_cmd(CMD_APPEND, 0, 0);
    send_cmd(CMD_REMOVE, 0, 0);
    send_cmd(CMD_APPEND, 32'hFFFF_FFFF, 5'd31);
    send_cmd(CMD_PREPEND, 32'h0000_0001, 0);
    send_cmd(CMD_APPEND, 32'hA5A5_5A5A, 0);
    send_cmd(CMD_APPEND, 32'hFFFF_FFFF, 0);
    send_cmd(CMD_PEEK, 0, 0);
    send_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 0);
    send_cmd(CMD_REMOVE, 32'h1234, 0);
    send_cmd(CMD_DROP_TAIL, 0, 2);
    send_cmd(CMD_POP, 0, 0);
    send_cmd(CMD_DROP_TAIL, 0, 0);
    // Fill to the limit, then try both inserts
    for (int i = 0; i < DEPTH; i++) send_cmd(CMD_APPEND, 32'h100 + i, 0, 1);
    send_cmd(CMD_APPEND, 32'h777, 0);
    send_cmd(CMD_PREPEND, 32'h777, 0);
    send_cmd(CMD_DROP_HEAD, 0, 5'd31);
    wait_drained();
  endtask

  // Random commands with a narrow value range so removes often hit
  task automatic test_random(input int count);
    cmd_e c;
    logic [31:0] d;
    for (int k = 0; k < count; k++) begin
      c = cmd_e'($urandom_range(0, 7));
      if (c == CMD_CLEAR && $urandom_range(0, 3) != 0) c = CMD_APPEND;
      if ($urandom_range(0, 2) == 0 && (c == CMD_APPEND || c == CMD_PREPEND)) c = CMD_APPEND;
      case ($urandom_range(0, 9))
        0: d = 0;
        1, 2: d = rand_word();
        default: d = $urandom_range(1, 12);
      endcase
      if (c == CMD_REMOVE && shadow_q.size() > 0 && $urandom_range(0, 1))
        d = shadow_q[$urandom_range(0, shadow_q.size() - 1)];
      send_cmd(c, d, 5'($urandom_range(0, 31)));
    end
    wait_drained();
  endtask

  // Receiver stalls long while the sender keeps offering inserts
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 20; i++) send_cmd(CMD_APPEND, rand_word(), 0, 1);
      end
    join
    send_cmd(CMD_DROP_TAIL, 0, 5'd16);
    wait_drained();
  endtask

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.command = CMD_APPEND;
    cmd_ch.data_value = '0;
    cmd_ch.amount = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(120);
    test_backpressure();
    test_random(120);
    repeat (20) @(negedge clk_i);
    if (error_count == 0) $display("double_ended_fifo_with_remove_test: done, clean");
    else $display("double_ended_fifo_with_remove_test: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+src
src/defr_pkg.sv
src/defr_if.sv
src/defr_datapath.sv
src/defr_ctrl.sv
src/double_ended_fifo_with_remove.sv
src/defr_checker.sv
tb/sv/defr_test_if.sv
tb/sv/double_ended_fifo_with_remove_test.sv
